// ===== design/mcma_pkg.sv =====
// Package with the sizing constants of the multichannel moving average.
package mcma_pkg;

  // Window length per channel and significant bits of each sample.
  localparam int WINDOW      = 16;
  localparam int SAMPLE_BITS = 12;
  localparam int NCHAN       = 4;

  // Fixed port widths.
  localparam int IN_W  = 12;
  localparam int OUT_W = 12;

  // Derived widths.
  localparam int STORE_W   = (SAMPLE_BITS < IN_W) ? SAMPLE_BITS : IN_W;
  localparam int CNT_W     = $clog2(WINDOW + 1);
  localparam int SUM_W     = STORE_W + CNT_W;
  localparam int PTR_W     = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CH_W      = $clog2(NCHAN);
  localparam int MEM_DEPTH = NCHAN * WINDOW;
  localparam int ADDR_W    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
  localparam int STEP_W    = $clog2(SUM_W);

endpackage

// ===== design/multichannel_moving_average.sv =====
// Four-channel boxcar moving average with warm-up, using one shared serial divider.
//
//   Channel  Handshake            Payload
//   -------  -------------------  ---------------------------------------
//   in       in_valid / in_stall  in_sample_ch0 .. in_sample_ch3 (12 bits)
//   out      out_valid/out_stall  out_average_ch0 .. out_average_ch3 (12 bits)
//
// For each channel in turn a word passes the read, update and divide states:
// one restoring divider producing one quotient bit per cycle is shared by all channels.
// The input is stalled while a word is being worked on; a finished average set
// waits in the output register, and a new input word may be taken meanwhile.
// Reset (rst_n, synchronous, active low) clears the sums, fill count and pointer;
// the window store needs no clearing, since a slot is only read after it is written.
module multichannel_moving_average
  import mcma_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [IN_W-1:0]  in_sample_ch0,
  input  logic [IN_W-1:0]  in_sample_ch1,
  input  logic [IN_W-1:0]  in_sample_ch2,
  input  logic [IN_W-1:0]  in_sample_ch3,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [OUT_W-1:0] out_average_ch0,
  output logic [OUT_W-1:0] out_average_ch1,
  output logic [OUT_W-1:0] out_average_ch2,
  output logic [OUT_W-1:0] out_average_ch3
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_READ   = 5'b00010,
    S_UPDATE = 5'b00100,
    S_DIVIDE = 5'b01000,
    S_FINISH = 5'b10000
  } state_t;

  // Control registers.
  state_t             state_r, state_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [CNT_W-1:0]   fill_r, fill_nxt;
  logic [PTR_W-1:0]   ptr_r, ptr_nxt;
  logic [SUM_W-1:0]   sums_r [NCHAN];
  logic [SUM_W-1:0]   sum_upd;
  logic               sum_we;

  // Word-level working registers.
  logic [STORE_W-1:0] samp_r [NCHAN];
  logic [OUT_W-1:0]   quo_r [NCHAN];
  logic [OUT_W-1:0]   avg_r [NCHAN];
  logic [CH_W-1:0]    ch_r, ch_nxt;
  logic               full_r, full_nxt;
  logic [PTR_W-1:0]   slot_r, slot_nxt;
  logic [CNT_W-1:0]   div_r, div_nxt;

  // Divider registers.
  logic [CNT_W-1:0]   rem_r, rem_nxt;
  logic [SUM_W-1:0]   dvd_r, dvd_nxt;
  logic [STEP_W-1:0]  step_r, step_nxt;

  // Window store.
  logic [STORE_W-1:0] win_mem [MEM_DEPTH];
  logic [STORE_W-1:0] rd_data_r;
  logic [ADDR_W-1:0]  mem_addr;
  logic               mem_we;

  logic               in_take;
  logic               out_free;
  logic [CNT_W:0]     rem_shift;
  logic [CNT_W:0]     rem_diff;
  logic               rem_ge;

  assign in_take  = in_valid && (state_r == S_IDLE);
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != S_IDLE);

  // Address of the current channel's slot in the window store.
  assign mem_addr = ADDR_W'(ch_r) * ADDR_W'(WINDOW) + ADDR_W'(slot_r);
  assign mem_we   = (state_r == S_UPDATE);

  // Running sum update: drop the oldest sample once the window is full.
  always_comb begin
    if (full_r) begin
      sum_upd = sums_r[ch_r] - SUM_W'(rd_data_r) + SUM_W'(samp_r[ch_r]);
    end else begin
      sum_upd = sums_r[ch_r] + SUM_W'(samp_r[ch_r]);
    end
  end
  assign sum_we = (state_r == S_UPDATE);

  // One restoring division step per cycle.
  assign rem_shift = {rem_r, dvd_r[SUM_W-1]};
  assign rem_diff  = rem_shift - {1'b0, div_r};
  assign rem_ge    = (rem_shift >= {1'b0, div_r});

  // Sequencer.
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    fill_nxt      = fill_r;
    ptr_nxt       = ptr_r;
    ch_nxt        = ch_r;
    full_nxt      = full_r;
    slot_nxt      = slot_r;
    div_nxt       = div_r;
    rem_nxt       = rem_r;
    dvd_nxt       = dvd_r;
    step_nxt      = step_r;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          ch_nxt = '0;
          if (fill_r >= CNT_W'(WINDOW)) begin
            full_nxt = 1'b1;
            slot_nxt = ptr_r;
            div_nxt  = CNT_W'(WINDOW);
            if (ptr_r == PTR_W'(WINDOW - 1)) begin
              ptr_nxt = '0;
            end else begin
              ptr_nxt = ptr_r + 1'b1;
            end
          end else begin
            full_nxt = 1'b0;
            slot_nxt = PTR_W'(fill_r);
            div_nxt  = fill_r + 1'b1;
            fill_nxt = fill_r + 1'b1;
          end
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        state_nxt = S_UPDATE;
      end
      S_UPDATE: begin
        rem_nxt   = '0;
        dvd_nxt   = sum_upd;
        step_nxt  = STEP_W'(SUM_W - 1);
        state_nxt = S_DIVIDE;
      end
      S_DIVIDE: begin
        rem_nxt  = rem_ge ? rem_diff[CNT_W-1:0] : rem_shift[CNT_W-1:0];
        dvd_nxt  = {dvd_r[SUM_W-2:0], rem_ge};
        step_nxt = step_r - 1'b1;
        if (step_r == '0) begin
          if (ch_r == CH_W'(NCHAN - 1)) begin
            state_nxt = S_FINISH;
          end else begin
            ch_nxt    = ch_r + 1'b1;
            state_nxt = S_READ;
          end
        end
      end
      S_FINISH: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state with reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      fill_r      <= '0;
      ptr_r       <= '0;
      for (int i = 0; i < NCHAN; i++) begin
        sums_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      fill_r      <= fill_nxt;
      ptr_r       <= ptr_nxt;
      if (sum_we) begin
        sums_r[ch_r] <= sum_upd;
      end
    end
  end

  // Working registers, no reset needed.
  always_ff @(posedge clk) begin
    ch_r   <= ch_nxt;
    full_r <= full_nxt;
    slot_r <= slot_nxt;
    div_r  <= div_nxt;
    rem_r  <= rem_nxt;
    dvd_r  <= dvd_nxt;
    step_r <= step_nxt;
    if (in_take) begin
      samp_r[0] <= STORE_W'(in_sample_ch0);
      samp_r[1] <= STORE_W'(in_sample_ch1);
      samp_r[2] <= STORE_W'(in_sample_ch2);
      samp_r[3] <= STORE_W'(in_sample_ch3);
    end
    if (state_r == S_DIVIDE && step_r == '0) begin
      quo_r[ch_r] <= OUT_W'(dvd_nxt);
    end
    if (state_r == S_FINISH && out_free) begin
      for (int i = 0; i < NCHAN; i++) begin
        avg_r[i] <= quo_r[i];
      end
    end
  end

  // Window store: the old sample is read in the cycle before the new one replaces it.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      win_mem[mem_addr] <= samp_r[ch_r];
    end
    rd_data_r <= win_mem[mem_addr];
  end

  assign out_valid       = out_valid_r;
  assign out_average_ch0 = avg_r[0];
  assign out_average_ch1 = avg_r[1];
  assign out_average_ch2 = avg_r[2];
  assign out_average_ch3 = avg_r[3];

endmodule

// ===== tb/sv/multichannel_moving_average_test.sv =====
// Self-checking testbench for the four-channel moving average block.
module multichannel_moving_average_test
  import mcma_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SAMPLE_MAX     = (1 << IN_W) - 1;
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned LONG_HOLD      = 600;
  localparam int unsigned DRAIN_CYCLES   = 150;
  localparam int unsigned MAX_REPORTS    = 10;

  typedef logic [NCHAN-1:0][IN_W-1:0]  sample_set_t;
  typedef logic [NCHAN-1:0][OUT_W-1:0] average_set_t;

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_stall;
  logic [IN_W-1:0]  in_sample_ch0;
  logic [IN_W-1:0]  in_sample_ch1;
  logic [IN_W-1:0]  in_sample_ch2;
  logic [IN_W-1:0]  in_sample_ch3;
  logic             out_valid;
  logic             out_stall;
  logic [OUT_W-1:0] out_average_ch0;
  logic [OUT_W-1:0] out_average_ch1;
  logic [OUT_W-1:0] out_average_ch2;
  logic [OUT_W-1:0] out_average_ch3;

  // Predictor state: sample history, running sums, fill level and oldest slot.
  logic [STORE_W-1:0] hist_mem [NCHAN][WINDOW];
  logic [31:0]        chan_sum [NCHAN];
  int unsigned        held_count;
  int unsigned        oldest_slot;

  average_set_t pending_averages[$];
  int unsigned  words_sent;
  int unsigned  words_checked;
  int unsigned  mismatch_count;
  int unsigned  idle_cycles;
  int unsigned  rx_hold_req;
  bit           tx_gaps_on;
  bit           rx_gaps_on;

  multichannel_moving_average DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_sample_ch0   (in_sample_ch0),
    .in_sample_ch1   (in_sample_ch1),
    .in_sample_ch2   (in_sample_ch2),
    .in_sample_ch3   (in_sample_ch3),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_average_ch0 (out_average_ch0),
    .out_average_ch1 (out_average_ch1),
    .out_average_ch2 (out_average_ch2),
    .out_average_ch3 (out_average_ch3)
  );

  // Free-running 20 ns clock.
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Advance the predicted window by one sample word and return the averages.
  function automatic average_set_t advance_average(input sample_set_t s);
    average_set_t       avg;
    logic [STORE_W-1:0] x;
    int unsigned        slot;
    int unsigned        divisor;
    bit                 full;
    full    = (held_count >= WINDOW);
    slot    = full ? oldest_slot : held_count;
    divisor = full ? WINDOW : held_count + 1;
    for (int ch = 0; ch < NCHAN; ch++) begin
      x = s[ch][STORE_W-1:0];
      if (full) begin
        chan_sum[ch] = chan_sum[ch] - 32'(hist_mem[ch][slot]) + 32'(x);
      end else begin
        chan_sum[ch] = chan_sum[ch] + 32'(x);
      end
      hist_mem[ch][slot] = x;
      avg[ch] = OUT_W'(chan_sum[ch] / divisor);
    end
    if (full) begin
      oldest_slot = (slot + 1) % WINDOW;
    end else begin
      held_count = held_count + 1;
    end
    return avg;
  endfunction

  // Random sample with extra weight on the range ends.
  function automatic logic [IN_W-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return IN_W'(SAMPLE_MAX);
      2: return IN_W'($urandom_range(0, 15));
      3: return IN_W'(SAMPLE_MAX - $urandom_range(0, 15));
      default: return IN_W'($urandom_range(0, SAMPLE_MAX));
    endcase
  endfunction

  // Offer one sample word, starting at a falling edge, and return at the
  // falling edge after it was taken; valid stays high for a following word.
  task automatic send_word(input sample_set_t s);
    if (tx_gaps_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_sample_ch0 <= s[0];
    in_sample_ch1 <= s[1];
    in_sample_ch2 <= s[2];
    in_sample_ch3 <= s[3];
    do begin
      @(posedge clk);
    end while (in_stall);
    pending_averages.push_back(advance_average(s));
    words_sent++;
    @(negedge clk);
  endtask

  // Drop valid after a burst of words.
  task automatic release_input();
    in_valid <= 1'b0;
    @(negedge clk);
  endtask

  // The very first word after reset: each average equals its sample.
  task automatic test_first_word();
    send_word({IN_W'(1), IN_W'(2048), IN_W'(0), IN_W'(SAMPLE_MAX)});
    release_input();
  endtask

  // Fill the rest of the window, so each word divides by a growing count.
  task automatic test_warmup();
    sample_set_t s;
    for (int k = 1; k < WINDOW; k++) begin
      s[0] = IN_W'(SAMPLE_MAX);
      s[1] = '0;
      s[2] = k[0] ? IN_W'(SAMPLE_MAX) : '0;
      s[3] = IN_W'(k * 273);
      send_word(s);
    end
    release_input();
  endtask

  // With a full window the oldest sample leaves the sum; channel 2 swings between
  // the extremes and the others sit at or near one, so the subtraction path is exercised.
  task automatic test_full_window();
    sample_set_t s;
    for (int k = 0; k < 8; k++) begin
      s[0] = '0;
      s[1] = IN_W'(SAMPLE_MAX);
      s[2] = k[1] ? '0 : IN_W'(SAMPLE_MAX);
      s[3] = IN_W'(SAMPLE_MAX - k);
      send_word(s);
    end
    release_input();
  endtask

  // Random words in segments. When asked, each segment picks its own
  // idling on either side; otherwise the current idling is kept.
  task automatic test_random_traffic(input int unsigned n_words, input bit vary_idling);
    sample_set_t s;
    int unsigned seg_len;
    int unsigned done_words;
    done_words = 0;
    while (done_words < n_words) begin
      seg_len = $urandom_range(40, 120);
      if (vary_idling) begin
        tx_gaps_on = ($urandom_range(0, 2) != 0);
        rx_gaps_on = ($urandom_range(0, 2) != 0);
      end
      for (int k = 0; k < seg_len && done_words < n_words; k++) begin
        for (int ch = 0; ch < NCHAN; ch++) begin
          s[ch] = pick_sample();
        end
        send_word(s);
        done_words++;
      end
    end
    release_input();
  endtask

  // The receiver holds off for a long stretch while words keep coming,
  // so the output register fills and the input is stalled.
  task automatic test_back_pressure();
    sample_set_t s;
    tx_gaps_on = 1'b0;
    rx_gaps_on = 1'b0;
    @(posedge clk);
    rx_hold_req = LONG_HOLD;
    @(negedge clk);
    for (int k = 0; k < 8; k++) begin
      for (int ch = 0; ch < NCHAN; ch++) begin
        s[ch] = pick_sample();
      end
      send_word(s);
    end
    release_input();
  endtask

  // Receiver stall: random bursts, plus the long hold on request.
  initial begin : rx_stall_gen
    int unsigned stall_left;
    stall_left = 0;
    out_stall  = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold_req != 0) begin
        stall_left  = rx_hold_req;
        rx_hold_req = 0;
      end else if (stall_left == 0 && rx_gaps_on && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(1, 17);
      end
      if (stall_left != 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Compare each accepted average word with the oldest prediction.
  always @(posedge clk) begin : check_results
    average_set_t got;
    average_set_t want;
    if (rst_n && out_valid && !out_stall) begin
      got = {out_average_ch3, out_average_ch2, out_average_ch1, out_average_ch0};
      if (pending_averages.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
          $display("%0t: unexpected average word %h", $realtime, got);
        end
      end else begin
        want = pending_averages.pop_front();
        words_checked++;
        for (int ch = 0; ch < NCHAN; ch++) begin
          if (got[ch] !== want[ch]) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS) begin
              $display("%0t: word %0d channel %0d average expected %0d, got %0d",
                       $realtime, words_checked, ch, want[ch], got[ch]);
            end
          end
        end
      end
    end
  end

  // Watchdog: give up when neither channel has moved for too long.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Timeout: no word moved for %0d cycles, %0d averages outstanding",
                 idle_cycles, pending_averages.size());
        $display("multichannel_moving_average verification failed");
        $finish;
      end
    end
  end

  // Test sequence.
  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_sample_ch0  = '0;
    in_sample_ch1  = '0;
    in_sample_ch2  = '0;
    in_sample_ch3  = '0;
    rx_hold_req    = 0;
    tx_gaps_on     = 1'b0;
    rx_gaps_on     = 1'b0;
    words_sent     = 0;
    words_checked  = 0;
    mismatch_count = 0;
    idle_cycles    = 0;
    held_count     = 0;
    oldest_slot    = 0;
    for (int ch = 0; ch < NCHAN; ch++) begin
      chan_sum[ch] = '0;
    end
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_first_word();
    tx_gaps_on = 1'b1;
    rx_gaps_on = 1'b1;
    test_warmup();
    test_full_window();
    test_random_traffic(600, 1'b1);
    test_back_pressure();
    test_random_traffic(600, 1'b1);

    // Closing stretch without any idling.
    tx_gaps_on = 1'b0;
    rx_gaps_on = 1'b0;
    test_random_traffic(250, 1'b0);
    tx_gaps_on = 1'b0;
    rx_gaps_on = 1'b0;

    while (pending_averages.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (pending_averages.size() != 0) begin
      mismatch_count++;
    end
    $display("Sent %0d sample words through warm-up, window wrap, back-pressure and",
             words_sent);
    $display("random traffic; checked %0d average words, %0d mismatches.",
             words_checked, mismatch_count);
    if (mismatch_count == 0) begin
      $display("multichannel_moving_average verification clean");
    end else begin
      $display("multichannel_moving_average verification failed");
    end
    $finish;
  end

endmodule
